>>> design/jddm_pkg.sv
// Shared constants, types and curve tables for the joystick mixer.
package jddm_pkg;

    localparam int HIST_DEPTH  = 3;
    localparam int SAMPLE_BITS = 12;
    localparam int CURVE_DEPTH = 256;

    localparam int PTR_W      = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
    localparam int SUM_W      = SAMPLE_BITS + PTR_W;
    localparam int CURVE_LOG2 = $clog2(CURVE_DEPTH);
    localparam int CURVE_KW   = $clog2(CURVE_DEPTH + 1);
    localparam int LOG_FRAC   = 24;

    localparam int MUL_W  = 17;
    localparam int PROD_W = 2 * MUL_W;
    localparam int DIV_NW = 28;
    localparam int DIV_DW = 16;

    localparam int APB_AW = 5;
    localparam int APB_DW = 32;

    localparam logic [15:0] ONE_Q15    = 16'd32768;
    localparam logic [16:0] SMOOTH_OLD = 17'd55706;
    localparam logic [16:0] SMOOTH_NEW = 17'd9830;

    localparam logic [11:0] RST_ADC_CENTER = 12'd2048;
    localparam logic [9:0]  RST_DEADZONE   = 10'd100;
    localparam logic [11:0] RST_ADC_MIN    = 12'd0;
    localparam logic [11:0] RST_ADC_MAX    = 12'd4095;
    localparam logic [6:0]  RST_MAX_SPEED  = 7'd74;

    typedef enum logic [2:0] {
        REG_ADC_CENTER = 3'd0,
        REG_DEADZONE   = 3'd1,
        REG_ADC_MIN    = 3'd2,
        REG_ADC_MAX    = 3'd3,
        REG_MAX_SPEED  = 3'd4
    } reg_idx_t;

    typedef enum logic [1:0] {
        CURVE_THR    = 2'd0,
        CURVE_STEER0 = 2'd1,
        CURVE_STEER1 = 2'd2
    } curve_sel_t;

    typedef struct packed {
        logic [11:0] adc_center;
        logic [9:0]  deadzone;
        logic [11:0] adc_min;
        logic [11:0] adc_max;
        logic [6:0]  max_speed;
    } cfg_t;

    typedef logic [15:0] curve_tab_t [0:CURVE_DEPTH];

    // base-2 log, 24 fraction bits, by repeated squaring
    function automatic longint log2_fix(input longint unsigned n);
        longint unsigned m;
        longint          frac;
        int              e;
        int              i;
        e = 0;
        while (e < 31 && (n >> (e + 1)) != 0)
        begin
            e++;
        end
        if (e > 30)
        begin
            e = 30;
        end
        m    = n << (30 - e);
        frac = 0;
        for (i = 0; i < LOG_FRAC; i++)
        begin
            m    = (m * m) >> 30;
            frac = frac * 2;
            if (m >= (64'd2 << 30))
            begin
                m    = m >> 1;
                frac = frac + 1;
            end
        end
        return (longint'(e) << LOG_FRAC) + frac;
    endfunction

    // entry k: largest y with b*(L(y)-15) <= a*(L(k)-L(depth))
    function automatic curve_tab_t build_curve(input longint a, input longint b);
        curve_tab_t      tab;
        longint          lgd;
        longint          fifteen;
        longint          rhs;
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned mid;
        int              k;
        lgd     = log2_fix(CURVE_DEPTH);
        fifteen = longint'(15) << LOG_FRAC;
        tab[0]  = 16'd0;
        for (k = 1; k <= CURVE_DEPTH; k++)
        begin
            rhs = a * (log2_fix(k) - lgd);
            lo  = 0;
            hi  = 32768;
            while (lo < hi)
            begin
                mid = (lo + hi + 1) >> 1;
                if (b * (log2_fix(mid) - fifteen) <= rhs)
                begin
                    lo = mid;
                end
                else
                begin
                    hi = mid - 1;
                end
            end
            tab[k] = 16'(lo);
        end
        return tab;
    endfunction

    localparam curve_tab_t CURVE_TAB_THR    = build_curve(3, 5);
    localparam curve_tab_t CURVE_TAB_STEER0 = build_curve(11, 10);
    localparam curve_tab_t CURVE_TAB_STEER1 = build_curve(8, 5);

    function automatic logic [15:0] curve_entry(input curve_sel_t sel,
                                                input logic [CURVE_KW-1:0] k);
        case (sel)
            CURVE_THR:    return CURVE_TAB_THR[k];
            CURVE_STEER0: return CURVE_TAB_STEER0[k];
            default:      return CURVE_TAB_STEER1[k];
        endcase
    endfunction

endpackage

>>> design/jddm_apb.sv
// Configuration register file with APB-style access.
module jddm_apb (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [jddm_pkg::APB_AW-1:0] paddr,
    input  logic [jddm_pkg::APB_DW-1:0] pwdata,
    output logic [jddm_pkg::APB_DW-1:0] prdata,
    output jddm_pkg::cfg_t              cfg
);

    jddm_pkg::cfg_t   cfg_reg;
    jddm_pkg::cfg_t   cfg_next;
    jddm_pkg::reg_idx_t idx;
    logic             wr_en;

    assign idx   = jddm_pkg::reg_idx_t'(paddr[jddm_pkg::APB_AW-1:2]);
    assign wr_en = psel & penable & pwrite;
    assign cfg   = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (idx)
                jddm_pkg::REG_ADC_CENTER: cfg_next.adc_center = pwdata[11:0];
                jddm_pkg::REG_DEADZONE:   cfg_next.deadzone   = pwdata[9:0];
                jddm_pkg::REG_ADC_MIN:    cfg_next.adc_min    = pwdata[11:0];
                jddm_pkg::REG_ADC_MAX:    cfg_next.adc_max    = pwdata[11:0];
                jddm_pkg::REG_MAX_SPEED:  cfg_next.max_speed  = pwdata[6:0];
                default:                  cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            jddm_pkg::REG_ADC_CENTER: prdata = jddm_pkg::APB_DW'(cfg_reg.adc_center);
            jddm_pkg::REG_DEADZONE:   prdata = jddm_pkg::APB_DW'(cfg_reg.deadzone);
            jddm_pkg::REG_ADC_MIN:    prdata = jddm_pkg::APB_DW'(cfg_reg.adc_min);
            jddm_pkg::REG_ADC_MAX:    prdata = jddm_pkg::APB_DW'(cfg_reg.adc_max);
            jddm_pkg::REG_MAX_SPEED:  prdata = jddm_pkg::APB_DW'(cfg_reg.max_speed);
            default:                  prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.adc_center <= jddm_pkg::RST_ADC_CENTER;
            cfg_reg.deadzone   <= jddm_pkg::RST_DEADZONE;
            cfg_reg.adc_min    <= jddm_pkg::RST_ADC_MIN;
            cfg_reg.adc_max    <= jddm_pkg::RST_ADC_MAX;
            cfg_reg.max_speed  <= jddm_pkg::RST_MAX_SPEED;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

>>> design/jddm_mul.sv
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
module jddm_mul (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [jddm_pkg::MUL_W-1:0]  a,
    input  logic [jddm_pkg::MUL_W-1:0]  b,
    output logic                        done,
    output logic [jddm_pkg::PROD_W-1:0] prod
);

    logic                        busy_reg, busy_next;
    logic                        done_reg, done_next;
    logic [jddm_pkg::PROD_W-1:0] a_reg, a_next;
    logic [jddm_pkg::MUL_W-1:0]  b_reg, b_next;
    logic [jddm_pkg::PROD_W-1:0] acc_reg, acc_next;

    assign done = done_reg;
    assign prod = acc_reg;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        a_next    = a_reg;
        b_next    = b_reg;
        acc_next  = acc_reg;
        if (start)
        begin
            busy_next = 1'b1;
            a_next    = jddm_pkg::PROD_W'(a);
            b_next    = b;
            acc_next  = '0;
        end
        else if (busy_reg)
        begin
            if (b_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                if (b_reg[0])
                begin
                    acc_next = acc_reg + a_reg;
                end
                a_next = a_reg << 1;
                b_next = b_reg >> 1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        acc_reg <= acc_next;
    end

endmodule

>>> design/jddm_div.sv
// Restoring divider, one quotient bit per cycle.
module jddm_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [jddm_pkg::DIV_NW-1:0] num,
    input  logic [jddm_pkg::DIV_DW-1:0] den,
    output logic                        done,
    output logic [jddm_pkg::DIV_NW-1:0] quo
);

    localparam int CNT_W = $clog2(jddm_pkg::DIV_NW);
    localparam int NW    = jddm_pkg::DIV_NW;
    localparam int DW    = jddm_pkg::DIV_DW;

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [NW-1:0]    num_reg, num_next;
    logic [DW-1:0]    den_reg, den_next;
    logic [DW-1:0]    rem_reg, rem_next;
    logic [DW:0]      rem_sh;
    logic [DW+1:0]    diff;
    logic             ge;

    assign done   = done_reg;
    assign quo    = num_reg;
    assign rem_sh = {rem_reg, num_reg[NW-1]};
    assign diff   = {1'b0, rem_sh} - {2'b00, den_reg};
    assign ge     = ~diff[DW+1];

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            num_next  = num;
            den_next  = den;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff[DW-1:0] : rem_sh[DW-1:0];
            num_next = {num_reg[NW-2:0], ge};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(NW - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
    end

endmodule

>>> design/joystick_differential_drive_mixer_unit.sv
// Joystick mixer: three-sample averaging, deadzone, power curves, smoothing, wheel mixing.
// The 28-bit serial divider (average, normalize, gain, steering limits, reverse speed) and
// the 17-bit serial multiplier dominate the time from input word to result word.
// Throughput: one word at a time; a new word is taken while the result waits.
// A toggle word flips the mode and gives no result.
// Reset (async, active low) clears history, smoothing state and mode, and loads defaults.
module joystick_differential_drive_mixer_unit (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [jddm_pkg::APB_AW-1:0]      paddr,
    input  logic [jddm_pkg::APB_DW-1:0]      pwdata,
    output logic [jddm_pkg::APB_DW-1:0]      prdata,
    output logic                             pready,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             command,
    input  logic [jddm_pkg::SAMPLE_BITS-1:0] joystick_x,
    input  logic [jddm_pkg::SAMPLE_BITS-1:0] joystick_y,
    input  logic                             forward_button,
    input  logic                             reverse_button,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [6:0]                       wheel_a_speed,
    output logic                             wheel_a_forward,
    output logic [6:0]                       wheel_b_speed,
    output logic                             wheel_b_forward
);

    localparam int SB = jddm_pkg::SAMPLE_BITS;
    localparam int HD = jddm_pkg::HIST_DEPTH;
    localparam int PW = jddm_pkg::PTR_W;
    localparam int KW = jddm_pkg::CURVE_KW;

    localparam logic [5:0]  STEER_BASE  = 6'd15;
    localparam logic [5:0]  STEER_CAP   = 6'd60;
    localparam logic [5:0]  STEER_SPAN  = 6'd45;
    localparam logic [4:0]  STEER_GAIN  = 5'd28;
    localparam logic [4:0]  TURN_GAIN   = 5'd30;
    localparam logic [3:0]  SPEED_BIAS  = 4'd6;
    localparam logic [6:0]  STEER1_MAX  = 7'd50;
    localparam logic [6:0]  SPEED_LIMIT = 7'd100;
    localparam logic [4:0]  GAIN_NUM    = 5'd20;
    localparam logic [4:0]  GAIN_DEN    = 5'd17;
    localparam logic [2:0]  REV_DEN     = 3'd5;

    typedef enum logic [15:0] {
        ST_IDLE  = 16'h0001,
        ST_AVGX  = 16'h0002,
        ST_AVGY  = 16'h0004,
        ST_NORM  = 16'h0008,
        ST_CURVE = 16'h0010,
        ST_GAIN  = 16'h0020,
        ST_SCALE = 16'h0040,
        ST_TSQ   = 16'h0080,
        ST_TSQ28 = 16'h0100,
        ST_MSQ   = 16'h0200,
        ST_CMDIV = 16'h0400,
        ST_MTDIV = 16'h0800,
        ST_SMOLD = 16'h1000,
        ST_SMNEW = 16'h2000,
        ST_REV   = 16'h4000,
        ST_FIN   = 16'h8000
    } state_t;

    typedef enum logic {
        JOB_THR   = 1'b0,
        JOB_STEER = 1'b1
    } job_t;

    jddm_pkg::cfg_t cfg;

    state_t state_reg, state_next;
    job_t   job_reg, job_next;
    job_t   sm_reg, sm_next;
    logic   pend_reg, pend_next;
    logic   mode_reg, mode_next;

    logic [SB-1:0] x_hist_reg [HD];
    logic [SB-1:0] x_hist_next [HD];
    logic [SB-1:0] y_hist_reg [HD];
    logic [SB-1:0] y_hist_next [HD];
    logic [PW-1:0] ptr_reg, ptr_next;

    logic signed [7:0] last_thr_reg, last_thr_next;
    logic signed [7:0] last_turn_reg, last_turn_next;
    logic signed [7:0] rx_reg, rx_next;
    logic signed [7:0] ry_reg, ry_next;

    logic [SB-1:0] avx_reg, avx_next;
    logic [SB-1:0] avy_reg, avy_next;
    logic [SB-1:0] src_reg, src_next;
    logic [15:0]   mag_reg, mag_next;
    logic          neg_reg, neg_next;
    logic [15:0]   c_reg, c_next;
    logic [5:0]    cm_reg, cm_next;
    logic [11:0]   mt_reg, mt_next;
    logic [18:0]   tmp_reg, tmp_next;
    logic [13:0]   mm_reg, mm_next;
    logic [23:0]   pold_reg, pold_next;
    logic [6:0]    rev_reg, rev_next;

    logic       out_valid_reg, out_valid_next;
    logic [6:0] sa_out_reg, sa_out_next;
    logic [6:0] sb_out_reg, sb_out_next;
    logic       dir_reg, dir_next;

    logic                          mul_start;
    logic [jddm_pkg::MUL_W-1:0]    mul_a;
    logic [jddm_pkg::MUL_W-1:0]    mul_b;
    logic                          mul_done;
    logic [jddm_pkg::PROD_W-1:0]   mul_p;
    logic                          div_start;
    logic [jddm_pkg::DIV_NW-1:0]   div_n;
    logic [jddm_pkg::DIV_DW-1:0]   div_d;
    logic                          div_done;
    logic [jddm_pkg::DIV_NW-1:0]   div_q;

    logic [jddm_pkg::SUM_W-1:0] sum_x;
    logic [jddm_pkg::SUM_W-1:0] sum_y;

    // normalize
    logic signed [12:0] nd;
    logic [11:0]        nad;
    logic               npos;
    logic               nbelow;
    logic [11:0]        nnum;
    logic signed [13:0] nden;
    logic               nden_le0;

    // curve lookup
    jddm_pkg::curve_sel_t csel;
    logic [KW-1:0]        ck;
    logic [KW-1:0]        ck1;
    logic [14:0]          cr;
    logic [15:0]          clo;
    logic [15:0]          chi;
    logic                 cend;

    logic [19:0]       c20;
    logic [6:0]        maxv;
    logic [6:0]        sc_mag;
    logic signed [7:0] sc_val;
    logic [6:0]        t_abs;
    logic [11:0]       t30;

    // smoothing
    logic signed [7:0]  sm_prev;
    logic signed [7:0]  sm_new;
    logic [7:0]         sm_prev_abs;
    logic [7:0]         sm_new_abs;
    logic signed [25:0] sm_sum;
    logic [24:0]        sm_abs;
    logic [7:0]         sm_mag;
    logic signed [7:0]  sm_res;
    logic signed [12:0] my_ext;
    logic signed [12:0] mt_ext;
    logic signed [7:0]  my_cl;

    // mixing
    logic [7:0]         thr_abs;
    logic signed [9:0]  speed;
    logic signed [9:0]  sa;
    logic signed [9:0]  sb;
    logic signed [9:0]  sa_cap;
    logic signed [9:0]  sb_cap;
    logic               fin_dir;

    assign pready          = 1'b1;
    assign in_ready        = (state_reg == ST_IDLE);
    assign out_valid       = out_valid_reg;
    assign wheel_a_speed   = sa_out_reg;
    assign wheel_b_speed   = sb_out_reg;
    assign wheel_a_forward = dir_reg;
    assign wheel_b_forward = dir_reg;

    jddm_apb u_apb (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    jddm_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .prod  (mul_p)
    );

    jddm_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_n),
        .den   (div_d),
        .done  (div_done),
        .quo   (div_q)
    );

    always_comb
    begin
        sum_x = '0;
        sum_y = '0;
        for (int i = 0; i < HD; i++)
        begin
            sum_x = sum_x + jddm_pkg::SUM_W'(x_hist_reg[i]);
            sum_y = sum_y + jddm_pkg::SUM_W'(y_hist_reg[i]);
        end
    end

    always_comb
    begin
        nd       = $signed({1'b0, src_reg}) - $signed({1'b0, cfg.adc_center});
        nad      = nd[12] ? 12'(-nd) : 12'(nd);
        npos     = ~nd[12] && (nd != '0);
        nbelow   = nad < {2'b00, cfg.deadzone};
        nnum     = nad - {2'b00, cfg.deadzone};
        if (npos)
        begin
            nden = $signed({2'b00, cfg.adc_max}) - $signed({2'b00, cfg.adc_center})
                   - $signed({4'b0000, cfg.deadzone});
        end
        else
        begin
            nden = $signed({2'b00, cfg.adc_center}) - $signed({2'b00, cfg.adc_min})
                   - $signed({4'b0000, cfg.deadzone});
        end
        nden_le0 = nden[13] || (nden == '0);
    end

    always_comb
    begin
        if (job_reg == JOB_THR)
        begin
            csel = jddm_pkg::CURVE_THR;
        end
        else if (!mode_reg)
        begin
            csel = jddm_pkg::CURVE_STEER0;
        end
        else
        begin
            csel = jddm_pkg::CURVE_STEER1;
        end
        ck   = KW'(mag_reg >> (15 - jddm_pkg::CURVE_LOG2));
        cr   = 15'(mag_reg << jddm_pkg::CURVE_LOG2);
        cend = ck >= KW'(jddm_pkg::CURVE_DEPTH);
        ck1  = cend ? ck : ck + 1'b1;
        clo  = jddm_pkg::curve_entry(csel, ck);
        chi  = jddm_pkg::curve_entry(csel, ck1);
    end

    always_comb
    begin
        c20 = (20'(c_reg) << 4) + (20'(c_reg) << 2);
        if (job_reg == JOB_THR)
        begin
            maxv = cfg.max_speed;
        end
        else if (!mode_reg)
        begin
            maxv = 7'(cm_reg);
        end
        else
        begin
            maxv = STEER1_MAX;
        end
        sc_mag = 7'(mul_p >> 15);
        sc_val = neg_reg ? -$signed({1'b0, sc_mag}) : $signed({1'b0, sc_mag});
        t_abs  = rx_reg[7] ? 7'(-rx_reg) : 7'(rx_reg);
        t30    = 12'(t_abs) * 12'(TURN_GAIN);
    end

    always_comb
    begin
        sm_prev     = (sm_reg == JOB_THR) ? last_thr_reg : last_turn_reg;
        sm_new      = (sm_reg == JOB_THR) ? rx_reg : ry_reg;
        sm_prev_abs = sm_prev[7] ? 8'(-sm_prev) : 8'(sm_prev);
        sm_new_abs  = sm_new[7] ? 8'(-sm_new) : 8'(sm_new);
        sm_sum      = (sm_prev[7] ? -$signed({2'b00, pold_reg}) : $signed({2'b00, pold_reg}))
                    + (sm_new[7] ? -$signed(26'(mul_p[23:0])) : $signed(26'(mul_p[23:0])));
        sm_abs      = sm_sum[25] ? 25'(-sm_sum) : 25'(sm_sum);
        sm_mag      = 8'(sm_abs >> 16);
        sm_res      = sm_sum[25] ? -$signed(sm_mag) : $signed(sm_mag);
        my_ext      = 13'(sm_res);
        mt_ext      = $signed({1'b0, mt_reg});
        if (my_ext > mt_ext)
        begin
            my_cl = 8'(mt_ext);
        end
        else if (my_ext < -mt_ext)
        begin
            my_cl = 8'(-mt_ext);
        end
        else
        begin
            my_cl = sm_res;
        end
    end

    always_comb
    begin
        thr_abs = last_thr_reg[7] ? 8'(-last_thr_reg) : 8'(last_thr_reg);
        speed   = '0;
        fin_dir = 1'b1;
        sa      = '0;
        sb      = '0;
        if (!mode_reg)
        begin
            fin_dir = last_thr_reg[7];
            speed   = $signed(10'(thr_abs) + 10'(SPEED_BIAS));
            sa      = speed + 10'(last_turn_reg);
            sb      = speed - 10'(last_turn_reg);
        end
        else if (forward_button_hold())
        begin
            speed = $signed(10'(cfg.max_speed));
            sa    = speed + 10'(last_turn_reg);
            sb    = speed - 10'(last_turn_reg);
        end
        else if (rev_btn_reg)
        begin
            fin_dir = 1'b0;
            speed   = $signed(10'(rev_reg));
            sa      = speed + 10'(last_turn_reg);
            sb      = speed - 10'(last_turn_reg);
        end
        sa_cap = (sa > $signed(10'(SPEED_LIMIT))) ? $signed(10'(SPEED_LIMIT)) : sa;
        sb_cap = (sb > $signed(10'(SPEED_LIMIT))) ? $signed(10'(SPEED_LIMIT)) : sb;
    end

    logic fwd_btn_reg, fwd_btn_next;
    logic rev_btn_reg, rev_btn_next;

    function automatic logic forward_button_hold();
        return fwd_btn_reg;
    endfunction

    always_comb
    begin
        state_next     = state_reg;
        job_next       = job_reg;
        sm_next        = sm_reg;
        pend_next      = pend_reg;
        mode_next      = mode_reg;
        x_hist_next    = x_hist_reg;
        y_hist_next    = y_hist_reg;
        ptr_next       = ptr_reg;
        last_thr_next  = last_thr_reg;
        last_turn_next = last_turn_reg;
        rx_next        = rx_reg;
        ry_next        = ry_reg;
        avx_next       = avx_reg;
        avy_next       = avy_reg;
        src_next       = src_reg;
        mag_next       = mag_reg;
        neg_next       = neg_reg;
        c_next         = c_reg;
        cm_next        = cm_reg;
        mt_next        = mt_reg;
        tmp_next       = tmp_reg;
        mm_next        = mm_reg;
        pold_next      = pold_reg;
        rev_next       = rev_reg;
        fwd_btn_next   = fwd_btn_reg;
        rev_btn_next   = rev_btn_reg;
        out_valid_next = out_valid_reg;
        sa_out_next    = sa_out_reg;
        sb_out_next    = sb_out_reg;
        dir_next       = dir_reg;
        mul_start      = 1'b0;
        mul_a          = '0;
        mul_b          = '0;
        div_start      = 1'b0;
        div_n          = '0;
        div_d          = '0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (command)
                    begin
                        mode_next      = ~mode_reg;
                        ptr_next       = '0;
                        last_thr_next  = '0;
                        last_turn_next = '0;
                        for (int i = 0; i < HD; i++)
                        begin
                            x_hist_next[i] = '0;
                            y_hist_next[i] = '0;
                        end
                    end
                    else
                    begin
                        x_hist_next[ptr_reg] = joystick_x;
                        if (!mode_reg)
                        begin
                            y_hist_next[ptr_reg] = joystick_y;
                        end
                        ptr_next     = (ptr_reg == PW'(HD - 1)) ? '0 : ptr_reg + 1'b1;
                        fwd_btn_next = forward_button;
                        rev_btn_next = reverse_button;
                        state_next   = ST_AVGX;
                    end
                end
            end

            ST_AVGX:
            begin
                if (!pend_reg)
                begin
                    div_start = 1'b1;
                    div_n     = jddm_pkg::DIV_NW'(sum_x);
                    div_d     = jddm_pkg::DIV_DW'(HD);
                    pend_next = 1'b1;
                end
                else if (div_done)
                begin
                    pend_next = 1'b0;
                    avx_next  = SB'(div_q);
                    if (!mode_reg)
                    begin
                        state_next = ST_AVGY;
                    end
                    else
                    begin
                        job_next   = JOB_STEER;
                        src_next   = SB'(div_q);
                        state_next = ST_NORM;
                    end
                end
            end

            ST_AVGY:
            begin
                if (!pend_reg)
                begin
                    div_start = 1'b1;
                    div_n     = jddm_pkg::DIV_NW'(sum_y);
                    div_d     = jddm_pkg::DIV_DW'(HD);
                    pend_next = 1'b1;
                end
                else if (div_done)
                begin
                    pend_next  = 1'b0;
                    avy_next   = SB'(div_q);
                    job_next   = JOB_THR;
                    src_next   = avx_reg;
                    state_next = ST_NORM;
                end
            end

            ST_NORM:
            begin
                neg_next = ~npos;
                if (!pend_reg)
                begin
                    if (nbelow || nnum == '0)
                    begin
                        mag_next   = '0;
                        state_next = ST_CURVE;
                    end
                    else if (nden_le0)
                    begin
                        mag_next   = jddm_pkg::ONE_Q15;
                        state_next = ST_CURVE;
                    end
                    else
                    begin
                        div_start = 1'b1;
                        div_n     = jddm_pkg::DIV_NW'({nnum, 15'd0});
                        div_d     = jddm_pkg::DIV_DW'(nden[11:0]);
                        pend_next = 1'b1;
                    end
                end
                else if (div_done)
                begin
                    pend_next  = 1'b0;
                    mag_next   = (div_q > jddm_pkg::DIV_NW'(jddm_pkg::ONE_Q15)) ?
                                 jddm_pkg::ONE_Q15 : 16'(div_q);
                    state_next = ST_CURVE;
                end
            end

            ST_CURVE:
            begin
                if (!pend_reg)
                begin
                    if (cend || chi < clo)
                    begin
                        c_next     = clo;
                        state_next = (job_reg == JOB_THR) ? ST_GAIN : ST_SCALE;
                    end
                    else
                    begin
                        mul_start = 1'b1;
                        mul_a     = jddm_pkg::MUL_W'(chi - clo);
                        mul_b     = jddm_pkg::MUL_W'(cr);
                        pend_next = 1'b1;
                    end
                end
                else if (mul_done)
                begin
                    pend_next  = 1'b0;
                    c_next     = clo + 16'(mul_p >> 15);
                    state_next = (job_reg == JOB_THR) ? ST_GAIN : ST_SCALE;
                end
            end

            ST_GAIN:
            begin
                if (!pend_reg)
                begin
                    div_start = 1'b1;
                    div_n     = jddm_pkg::DIV_NW'(c20);
                    div_d     = jddm_pkg::DIV_DW'(GAIN_DEN);
                    pend_next = 1'b1;
                end
                else if (div_done)
                begin
                    pend_next  = 1'b0;
                    c_next     = (div_q > jddm_pkg::DIV_NW'(jddm_pkg::ONE_Q15)) ?
                                 jddm_pkg::ONE_Q15 : 16'(div_q);
                    state_next = ST_SCALE;
                end
            end

            ST_SCALE:
            begin
                if (!pend_reg)
                begin
                    mul_start = 1'b1;
                    mul_a     = jddm_pkg::MUL_W'(c_reg);
                    mul_b     = jddm_pkg::MUL_W'(maxv);
                    pend_next = 1'b1;
                end
                else if (mul_done)
                begin
                    pend_next = 1'b0;
                    if (job_reg == JOB_THR)
                    begin
                        rx_next = sc_val;
                        if (cfg.max_speed != '0)
                        begin
                            state_next = ST_TSQ;
                        end
                        else
                        begin
                            cm_next    = STEER_BASE;
                            mt_next    = 12'(STEER_BASE);
                            job_next   = JOB_STEER;
                            src_next   = avy_reg;
                            state_next = ST_NORM;
                        end
                    end
                    else
                    begin
                        ry_next    = sc_val;
                        sm_next    = mode_reg ? JOB_STEER : JOB_THR;
                        state_next = ST_SMOLD;
                    end
                end
            end

            ST_TSQ:
            begin
                if (!pend_reg)
                begin
                    mul_start = 1'b1;
                    mul_a     = jddm_pkg::MUL_W'(t_abs);
                    mul_b     = jddm_pkg::MUL_W'(t_abs);
                    pend_next = 1'b1;
                end
                else if (mul_done)
                begin
                    pend_next  = 1'b0;
                    tmp_next   = 19'(mul_p);
                    state_next = ST_TSQ28;
                end
            end

            ST_TSQ28:
            begin
                if (!pend_reg)
                begin
                    mul_start = 1'b1;
                    mul_a     = jddm_pkg::MUL_W'(tmp_reg);
                    mul_b     = jddm_pkg::MUL_W'(STEER_GAIN);
                    pend_next = 1'b1;
                end
                else if (mul_done)
                begin
                    pend_next  = 1'b0;
                    tmp_next   = 19'(mul_p);
                    state_next = ST_MSQ;
                end
            end

            ST_MSQ:
            begin
                if (!pend_reg)
                begin
                    mul_start = 1'b1;
                    mul_a     = jddm_pkg::MUL_W'(cfg.max_speed);
                    mul_b     = jddm_pkg::MUL_W'(cfg.max_speed);
                    pend_next = 1'b1;
                end
                else if (mul_done)
                begin
                    pend_next  = 1'b0;
                    mm_next    = 14'(mul_p);
                    state_next = ST_CMDIV;
                end
            end

            ST_CMDIV:
            begin
                if (!pend_reg)
                begin
                    div_start = 1'b1;
                    div_n     = jddm_pkg::DIV_NW'(tmp_reg);
                    div_d     = jddm_pkg::DIV_DW'(mm_reg);
                    pend_next = 1'b1;
                end
                else if (div_done)
                begin
                    pend_next  = 1'b0;
                    cm_next    = (div_q > jddm_pkg::DIV_NW'(STEER_SPAN)) ?
                                 STEER_CAP : STEER_BASE + 6'(div_q);
                    state_next = ST_MTDIV;
                end
            end

            ST_MTDIV:
            begin
                if (!pend_reg)
                begin
                    div_start = 1'b1;
                    div_n     = jddm_pkg::DIV_NW'(t30);
                    div_d     = jddm_pkg::DIV_DW'(cfg.max_speed);
                    pend_next = 1'b1;
                end
                else if (div_done)
                begin
                    pend_next  = 1'b0;
                    mt_next    = 12'(STEER_BASE) + 12'(div_q);
                    job_next   = JOB_STEER;
                    src_next   = avy_reg;
                    state_next = ST_NORM;
                end
            end

            ST_SMOLD:
            begin
                if (!pend_reg)
                begin
                    mul_start = 1'b1;
                    mul_a     = jddm_pkg::MUL_W'(sm_prev_abs);
                    mul_b     = jddm_pkg::SMOOTH_OLD;
                    pend_next = 1'b1;
                end
                else if (mul_done)
                begin
                    pend_next  = 1'b0;
                    pold_next  = 24'(mul_p);
                    state_next = ST_SMNEW;
                end
            end

            ST_SMNEW:
            begin
                if (!pend_reg)
                begin
                    mul_start = 1'b1;
                    mul_a     = jddm_pkg::MUL_W'(sm_new_abs);
                    mul_b     = jddm_pkg::SMOOTH_NEW;
                    pend_next = 1'b1;
                end
                else if (mul_done)
                begin
                    pend_next = 1'b0;
                    if (sm_reg == JOB_THR)
                    begin
                        last_thr_next = sm_res;
                        sm_next       = JOB_STEER;
                        state_next    = ST_SMOLD;
                    end
                    else if (!mode_reg)
                    begin
                        last_turn_next = my_cl;
                        state_next     = ST_FIN;
                    end
                    else
                    begin
                        last_turn_next = sm_res;
                        state_next     = ST_REV;
                    end
                end
            end

            ST_REV:
            begin
                if (!pend_reg)
                begin
                    div_start = 1'b1;
                    div_n     = jddm_pkg::DIV_NW'({cfg.max_speed, 2'b00});
                    div_d     = jddm_pkg::DIV_DW'(REV_DEN);
                    pend_next = 1'b1;
                end
                else if (div_done)
                begin
                    pend_next  = 1'b0;
                    rev_next   = 7'(div_q);
                    state_next = ST_FIN;
                end
            end

            ST_FIN:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    sa_out_next    = sa_cap[9] ? 7'(-sa_cap) : 7'(sa_cap);
                    sb_out_next    = sb_cap[9] ? 7'(-sb_cap) : 7'(sb_cap);
                    dir_next       = fin_dir;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
                pend_next  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            job_reg       <= JOB_THR;
            sm_reg        <= JOB_THR;
            pend_reg      <= 1'b0;
            mode_reg      <= 1'b0;
            ptr_reg       <= '0;
            last_thr_reg  <= '0;
            last_turn_reg <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < HD; i++)
            begin
                x_hist_reg[i] <= '0;
                y_hist_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            job_reg       <= job_next;
            sm_reg        <= sm_next;
            pend_reg      <= pend_next;
            mode_reg      <= mode_next;
            ptr_reg       <= ptr_next;
            last_thr_reg  <= last_thr_next;
            last_turn_reg <= last_turn_next;
            out_valid_reg <= out_valid_next;
            x_hist_reg    <= x_hist_next;
            y_hist_reg    <= y_hist_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rx_reg      <= rx_next;
        ry_reg      <= ry_next;
        avx_reg     <= avx_next;
        avy_reg     <= avy_next;
        src_reg     <= src_next;
        mag_reg     <= mag_next;
        neg_reg     <= neg_next;
        c_reg       <= c_next;
        cm_reg      <= cm_next;
        mt_reg      <= mt_next;
        tmp_reg     <= tmp_next;
        mm_reg      <= mm_next;
        pold_reg    <= pold_next;
        rev_reg     <= rev_next;
        fwd_btn_reg <= fwd_btn_next;
        rev_btn_reg <= rev_btn_next;
        sa_out_reg  <= sa_out_next;
        sb_out_reg  <= sb_out_next;
        dir_reg     <= dir_next;
    end

endmodule
